/* rtl/core/assoc_cache_fifo_random_wb_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the associative cache block
// Shared property shapes used by the port checker.
// ----------------------------------------------------------------------------
`ifndef ASSOC_CACHE_FIFO_RANDOM_WB_DEFINES_SVH
`define ASSOC_CACHE_FIFO_RANDOM_WB_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ACWB_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ACWB_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/acwb_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acwb_pkg
// Types, widths and constants shared by the associative cache block.
// ----------------------------------------------------------------------------
package acwb_pkg;

  localparam int unsigned DEF_NUM_LINES   = 4;
  localparam int unsigned DEF_BLOCK_WORDS = 4;
  localparam int unsigned DEF_MEM_WORDS   = 4096;

  localparam int unsigned OP_W       = 2;
  localparam int unsigned ADDR_W     = 12;
  localparam int unsigned DATA_W     = 16;
  localparam int unsigned LINE_OUT_W = 2;
  localparam int unsigned OFF_OUT_W  = 2;
  localparam int unsigned BLK_OUT_W  = 10;
  localparam int unsigned CNT_W      = 16;
  localparam int unsigned LFSR_W     = 16;

  localparam logic [LFSR_W-1:0] LFSR_SEED = 16'hACE1;
  localparam logic [LFSR_W-1:0] LFSR_TAPS = 16'hB400;

  typedef enum logic [OP_W-1:0] {
    OP_READ    = 2'd0,
    OP_WRITE   = 2'd1,
    OP_PRELOAD = 2'd2,
    OP_NONE    = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    KIND_NOP     = 3'd0,
    KIND_PRELOAD = 3'd1,
    KIND_HIT_RD  = 3'd2,
    KIND_HIT_WR  = 3'd3,
    KIND_FILL    = 3'd4,
    KIND_REPLACE = 3'd5
  } kind_e;

  typedef struct packed {
    logic accept;
    logic lookup;
    logic hit_capture;
    logic wb_step;
    logic load_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    kind_e kind;
    logic  step_last;
  } status_t;

endpackage

/* rtl/core/acwb_req_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acwb_req_if
// Request channel: operation, word address and write data.
// ----------------------------------------------------------------------------
interface acwb_req_if import acwb_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [ADDR_W-1:0] address;
  logic [DATA_W-1:0] write_data;

  modport source (output valid, operation, address, write_data, input ready);
  modport sink   (input valid, operation, address, write_data, output ready);
endinterface

/* rtl/core/acwb_rsp_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acwb_rsp_if
// Response channel: one result word per request.
// ----------------------------------------------------------------------------
interface acwb_rsp_if import acwb_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic                  hit;
  logic [LINE_OUT_W-1:0] line_index;
  logic [OFF_OUT_W-1:0]  word_offset;
  logic [DATA_W-1:0]     read_data;
  logic                  replaced;
  logic [BLK_OUT_W-1:0]  replaced_block;
  logic [CNT_W-1:0]      line_accesses;

  modport source (output valid, hit, line_index, word_offset, read_data, replaced,
                  replaced_block, line_accesses, input ready);
  modport sink   (input valid, hit, line_index, word_offset, read_data, replaced,
                  replaced_block, line_accesses, output ready);
endinterface

/* rtl/core/acwb_cfg_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acwb_cfg_if
// Configuration write channel for the replacement mode register.
// ----------------------------------------------------------------------------
interface acwb_cfg_if ();
  logic valid;
  logic ready;
  logic replacement_mode;

  modport source (output valid, replacement_mode, input ready);
  modport sink   (input valid, replacement_mode, output ready);
endinterface

/* rtl/core/acwb_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acwb_dp
// Cache datapath: tag lookup, line state, FIFO order, LFSR, cache word
// memory, backing memory and the result register.
// ----------------------------------------------------------------------------
module acwb_dp import acwb_pkg::*; #(
  parameter int unsigned NUM_LINES   = DEF_NUM_LINES,
  parameter int unsigned BLOCK_WORDS = DEF_BLOCK_WORDS,
  parameter int unsigned MEM_WORDS   = DEF_MEM_WORDS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cmd_t                  cmd_i,
  output status_t               status_o,
  input  logic [OP_W-1:0]       operation_i,
  input  logic [ADDR_W-1:0]     address_i,
  input  logic [DATA_W-1:0]     write_data_i,
  input  logic                  cfg_we_i,
  input  logic                  cfg_mode_i,
  output logic                  hit_o,
  output logic [LINE_OUT_W-1:0] line_index_o,
  output logic [OFF_OUT_W-1:0]  word_offset_o,
  output logic [DATA_W-1:0]     read_data_o,
  output logic                  replaced_o,
  output logic [BLK_OUT_W-1:0]  replaced_block_o,
  output logic [CNT_W-1:0]      line_accesses_o
);

  // All three sizes must be powers of two; the module does not check this.
  localparam int unsigned LW    = $clog2(NUM_LINES);
  localparam int unsigned OFF_W = $clog2(BLOCK_WORDS);
  localparam int unsigned MAW   = $clog2(MEM_WORDS);
  localparam int unsigned BLK_W = ADDR_W - OFF_W;
  localparam int unsigned CW    = LW + OFF_W;
  localparam int unsigned SW    = $clog2(BLOCK_WORDS + 1);
  localparam int unsigned CACHE_DEPTH = NUM_LINES * BLOCK_WORDS;
  localparam logic [ADDR_W-1:0] ADDR_MASK =
    (MAW >= ADDR_W) ? {ADDR_W{1'b1}} : ADDR_W'((1 << MAW) - 1);

  // Request registers.
  op_e               op_q;
  logic [ADDR_W-1:0] addr_q;
  logic [DATA_W-1:0] wdata_q;

  // Line state.
  logic [NUM_LINES-1:0] valid_q;
  logic [BLK_W-1:0]     blk_q  [NUM_LINES];
  logic [LW-1:0]        fifo_q [NUM_LINES];
  logic [CNT_W-1:0]     cnt_q  [NUM_LINES];
  logic [LFSR_W-1:0]    lfsr_q;
  logic                 mode_q;
  logic [SW-1:0]        step_q;

  // Per-item working registers.
  kind_e             kind_q;
  logic [LW-1:0]     line_q;
  logic [BLK_W-1:0]  vblock_q;
  logic [DATA_W-1:0] word_q;

  // Result register.
  logic                  out_hit_q;
  logic [LINE_OUT_W-1:0] out_line_q;
  logic [OFF_OUT_W-1:0]  out_off_q;
  logic [DATA_W-1:0]     out_data_q;
  logic                  out_repl_q;
  logic [BLK_OUT_W-1:0]  out_rblk_q;
  logic [CNT_W-1:0]      out_acc_q;

  // Memories.
  logic [DATA_W-1:0] cache_mem   [CACHE_DEPTH];
  logic [DATA_W-1:0] backing_mem [MEM_WORDS];
  logic [DATA_W-1:0] cache_rd_q;
  logic [DATA_W-1:0] mem_rd_q;

  logic [BLK_W-1:0]  req_blk;
  logic [OFF_W-1:0]  req_off;
  logic              hit_any;
  logic [LW-1:0]     hit_line;
  logic              empty_any;
  logic [LW-1:0]     free_line;
  kind_e             kind;
  logic [LFSR_W-1:0] lfsr_next;
  logic [LW-1:0]     victim;
  logic [LW-1:0]     fifo_mv [NUM_LINES];
  logic              step_last;
  logic [SW-1:0]     prev_step;
  logic [OFF_W-1:0]  cur_off;
  logic [OFF_W-1:0]  prev_off;

  logic              mem_we;
  logic              mem_re;
  logic [MAW-1:0]    mem_addr;
  logic [DATA_W-1:0] mem_wd;
  logic              c_we;
  logic              c_re;
  logic [CW-1:0]     c_waddr;
  logic [CW-1:0]     c_raddr;
  logic [DATA_W-1:0] c_wd;

  assign req_blk   = addr_q[ADDR_W-1:OFF_W];
  assign req_off   = addr_q[OFF_W-1:0];
  assign step_last = (step_q == SW'(BLOCK_WORDS));
  assign prev_step = step_q - SW'(1);
  assign cur_off   = step_q[OFF_W-1:0];
  assign prev_off  = prev_step[OFF_W-1:0];

  // Tag compare against every line; lines fill from the bottom and never
  // empty again, so the first empty line is also the FIFO fill position.
  always_comb begin
    hit_any   = 1'b0;
    hit_line  = '0;
    empty_any = 1'b0;
    free_line = '0;
    for (int i = 0; i < NUM_LINES; i++) begin
      if (valid_q[i] && (blk_q[i] == req_blk) && !hit_any) begin
        hit_any  = 1'b1;
        hit_line = LW'(i);
      end
      if (!valid_q[i] && !empty_any) begin
        empty_any = 1'b1;
        free_line = LW'(i);
      end
    end
  end

  always_comb begin
    unique case (op_q)
      OP_PRELOAD: kind = KIND_PRELOAD;
      OP_NONE:    kind = KIND_NOP;
      OP_READ, OP_WRITE: begin
        if (hit_any) begin
          kind = (op_q == OP_WRITE) ? KIND_HIT_WR : KIND_HIT_RD;
        end else if (empty_any) begin
          kind = KIND_FILL;
        end else begin
          kind = KIND_REPLACE;
        end
      end
    endcase
  end

  assign lfsr_next = {1'b0, lfsr_q[LFSR_W-1:1]} ^ (lfsr_q[0] ? LFSR_TAPS : '0);
  assign victim    = mode_q ? fifo_q[0] : lfsr_next[LW-1:0];

  // The victim leaves its place in the FIFO and goes to the back.
  always_comb begin
    logic seen;
    seen = 1'b0;
    for (int i = 0; i < NUM_LINES - 1; i++) begin
      seen       = seen | (fifo_q[i] == victim);
      fifo_mv[i] = seen ? fifo_q[i+1] : fifo_q[i];
    end
    fifo_mv[NUM_LINES-1] = victim;
  end

  assign status_o.kind      = kind;
  assign status_o.step_last = step_last;

  // Backing memory port: preload writes, write-back writes, block loads.
  always_comb begin
    mem_we   = 1'b0;
    mem_re   = 1'b0;
    mem_addr = MAW'(addr_q);
    mem_wd   = wdata_q;
    if (cmd_i.lookup && (kind == KIND_PRELOAD)) begin
      mem_we = 1'b1;
    end else if (cmd_i.wb_step && (step_q != '0)) begin
      mem_we   = 1'b1;
      mem_addr = MAW'({vblock_q, prev_off});
      mem_wd   = cache_rd_q;
    end else if (cmd_i.load_step && !step_last) begin
      mem_re   = 1'b1;
      mem_addr = MAW'({req_blk, cur_off});
    end
  end

  // Cache word memory ports.
  always_comb begin
    c_re    = (cmd_i.lookup && (kind == KIND_HIT_RD)) || (cmd_i.wb_step && !step_last);
    c_raddr = cmd_i.lookup ? {hit_line, req_off} : {line_q, cur_off};
    c_we    = (cmd_i.lookup && (kind == KIND_HIT_WR)) ||
              (cmd_i.load_step && (step_q != '0));
    c_waddr = cmd_i.lookup ? {hit_line, req_off} : {line_q, prev_off};
    c_wd    = cmd_i.lookup ? wdata_q : mem_rd_q;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      backing_mem[mem_addr] <= mem_wd;
    end else if (mem_re) begin
      mem_rd_q <= backing_mem[mem_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (c_we) begin
      cache_mem[c_waddr] <= c_wd;
    end
    if (c_re) begin
      cache_rd_q <= cache_mem[c_raddr];
    end
  end

  // Line state, FIFO order, LFSR and mode.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      for (int i = 0; i < NUM_LINES; i++) begin
        blk_q[i]  <= '0;
        fifo_q[i] <= '0;
        cnt_q[i]  <= '0;
      end
      lfsr_q <= LFSR_SEED;
      mode_q <= 1'b0;
      step_q <= '0;
    end else begin
      if (cfg_we_i) begin
        mode_q <= cfg_mode_i;
      end
      if (cmd_i.lookup) begin
        step_q <= '0;
        unique case (kind)
          KIND_HIT_RD, KIND_HIT_WR: begin
            if (cnt_q[hit_line] != {CNT_W{1'b1}}) begin
              cnt_q[hit_line] <= cnt_q[hit_line] + CNT_W'(1);
            end
          end
          KIND_FILL: begin
            valid_q[free_line] <= 1'b1;
            blk_q[free_line]   <= req_blk;
            cnt_q[free_line]   <= '0;
            fifo_q[free_line]  <= free_line;
          end
          KIND_REPLACE: begin
            blk_q[victim] <= req_blk;
            cnt_q[victim] <= '0;
            fifo_q        <= fifo_mv;
            if (!mode_q) begin
              lfsr_q <= lfsr_next;
            end
          end
          default: begin
          end
        endcase
      end else if (cmd_i.wb_step || cmd_i.load_step) begin
        step_q <= step_last ? '0 : step_q + SW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q <= OP_NONE;
    end else if (cmd_i.accept) begin
      op_q <= op_e'(operation_i);
    end
  end

  // Request and per-item working registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      addr_q  <= address_i & ADDR_MASK;
      wdata_q <= write_data_i;
    end
    if (cmd_i.lookup) begin
      kind_q   <= kind;
      vblock_q <= blk_q[victim];
      line_q   <= (kind == KIND_REPLACE) ? victim :
                  (kind == KIND_FILL) ? free_line : hit_line;
      if ((kind == KIND_PRELOAD) || (kind == KIND_HIT_WR)) begin
        word_q <= wdata_q;
      end
    end
    if (cmd_i.hit_capture) begin
      word_q <= cache_rd_q;
    end
    // The requested word is taken as it streams into the line.
    if (cmd_i.load_step && (step_q != '0) && (prev_off == req_off)) begin
      word_q <= mem_rd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      unique case (kind_q)
        KIND_PRELOAD: begin
          out_hit_q  <= 1'b0;
          out_line_q <= '0;
          out_off_q  <= '0;
          out_data_q <= word_q;
          out_repl_q <= 1'b0;
          out_rblk_q <= '0;
          out_acc_q  <= '0;
        end
        KIND_NOP: begin
          out_hit_q  <= 1'b0;
          out_line_q <= '0;
          out_off_q  <= '0;
          out_data_q <= '0;
          out_repl_q <= 1'b0;
          out_rblk_q <= '0;
          out_acc_q  <= '0;
        end
        default: begin
          out_hit_q  <= (kind_q == KIND_HIT_RD) || (kind_q == KIND_HIT_WR);
          out_line_q <= LINE_OUT_W'(line_q);
          out_off_q  <= OFF_OUT_W'(req_off);
          out_data_q <= word_q;
          out_repl_q <= (kind_q == KIND_REPLACE);
          out_rblk_q <= (kind_q == KIND_REPLACE) ? BLK_OUT_W'(vblock_q) : '0;
          out_acc_q  <= cnt_q[line_q];
        end
      endcase
    end
  end

  assign hit_o            = out_hit_q;
  assign line_index_o     = out_line_q;
  assign word_offset_o    = out_off_q;
  assign read_data_o      = out_data_q;
  assign replaced_o       = out_repl_q;
  assign replaced_block_o = out_rblk_q;
  assign line_accesses_o  = out_acc_q;

endmodule

/* rtl/core/acwb_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acwb_ctrl
// Sequencer for one access: lookup, write-back, block load and result.
// ----------------------------------------------------------------------------
module acwb_ctrl import acwb_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_LOOKUP = 6'b000010,
    S_HITRD  = 6'b000100,
    S_WB     = 6'b001000,
    S_LOAD   = 6'b010000,
    S_FINISH = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  cmd_t   cmd;

  always_comb begin
    state_d = state_q;
    cmd     = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd.accept = 1'b1;
          state_d    = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        cmd.lookup = 1'b1;
        unique case (status_i.kind)
          KIND_HIT_RD:  state_d = S_HITRD;
          KIND_FILL:    state_d = S_LOAD;
          KIND_REPLACE: state_d = S_WB;
          default:      state_d = S_FINISH;
        endcase
      end
      S_HITRD: begin
        cmd.hit_capture = 1'b1;
        state_d         = S_FINISH;
      end
      S_WB: begin
        cmd.wb_step = 1'b1;
        if (status_i.step_last) begin
          state_d = S_LOAD;
        end
      end
      S_LOAD: begin
        cmd.load_step = 1'b1;
        if (status_i.step_last) begin
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        // Wait here only while the previous word is still unclaimed.
        if (!out_valid_q || out_ready_i) begin
          cmd.out_load = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign cmd_o       = cmd;

endmodule

/* rtl/core/assoc_cache_fifo_random_wb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// assoc_cache_fifo_random_wb
// Fully associative write-back cache with FIFO or LFSR victim choice.
// ----------------------------------------------------------------------------
// Requests arrive on req_i (read, write, preload of a backing word) and each
// one yields exactly one word on rsp_o. cfg_i writes the replacement mode
// (0 LFSR victim, 1 FIFO victim) and is always ready; write it only while
// no request is in flight.
// One request is worked on at a time. Steps from acceptance to the result
// register, with B words per block:
//   preload, unused operation, write hit: lookup only
//   read hit: lookup, then one registered cache read
//   miss into an empty line: lookup, then a block load through the memory port
//   miss with eviction: lookup, write-back of B words, then load of B words
// req_i is ready again as soon as the result is registered. The single-port
// backing memory sets the miss cost.
// A result waits in the output register while rsp_o is stalled; the next
// request is still taken and worked on, and holds only at its result step.
// Reset empties all lines, clears counters and FIFO order and seeds the
// LFSR. Backing memory and cache words are not cleared.
// ----------------------------------------------------------------------------
module assoc_cache_fifo_random_wb import acwb_pkg::*; #(
  parameter int unsigned NUM_LINES   = DEF_NUM_LINES,
  parameter int unsigned BLOCK_WORDS = DEF_BLOCK_WORDS,
  parameter int unsigned MEM_WORDS   = DEF_MEM_WORDS
) (
  input logic           clk_i,
  input logic           rst_ni,
  acwb_req_if.sink      req_i,
  acwb_rsp_if.source    rsp_o,
  acwb_cfg_if.sink      cfg_i
);

  cmd_t    cmd;
  status_t status;

  assign cfg_i.ready = 1'b1;

  acwb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  acwb_dp #(
    .NUM_LINES   (NUM_LINES),
    .BLOCK_WORDS (BLOCK_WORDS),
    .MEM_WORDS   (MEM_WORDS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .operation_i      (req_i.operation),
    .address_i        (req_i.address),
    .write_data_i     (req_i.write_data),
    .cfg_we_i         (cfg_i.valid),
    .cfg_mode_i       (cfg_i.replacement_mode),
    .hit_o            (rsp_o.hit),
    .line_index_o     (rsp_o.line_index),
    .word_offset_o    (rsp_o.word_offset),
    .read_data_o      (rsp_o.read_data),
    .replaced_o       (rsp_o.replaced),
    .replaced_block_o (rsp_o.replaced_block),
    .line_accesses_o  (rsp_o.line_accesses)
  );

endmodule

/* rtl/core/acwb_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acwb_checker
// Port-level checks on the associative cache, attached by bind.
// ----------------------------------------------------------------------------
`include "assoc_cache_fifo_random_wb_defines.svh"

module acwb_checker import acwb_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 req_valid_i,
  input logic                 req_ready_i,
  input logic                 rsp_valid_i,
  input logic                 rsp_ready_i,
  input logic                 rsp_hit_i,
  input logic [DATA_W-1:0]    rsp_read_data_i,
  input logic                 rsp_replaced_i,
  input logic [BLK_OUT_W-1:0] rsp_replaced_block_i,
  input logic [CNT_W-1:0]     rsp_line_accesses_i
);

  // A stalled result word must hold.
  `ACWB_ASSERT_NXT(a_rsp_hold, clk_i, rst_ni, rsp_valid_i && !rsp_ready_i, rsp_valid_i && $stable(rsp_read_data_i), "stalled result changed")

  // Only one request is in flight.
  `ACWB_ASSERT_NXT(a_one_in_flight, clk_i, rst_ni, req_valid_i && req_ready_i, !req_ready_i, "request taken while busy")

  // An eviction only happens on a miss.
  `ACWB_ASSERT_IMP(a_repl_is_miss, clk_i, rst_ni, rsp_valid_i && rsp_replaced_i, !rsp_hit_i, "eviction reported on a hit")

  // A line just filled has not been hit yet.
  `ACWB_ASSERT_IMP(a_miss_count_zero, clk_i, rst_ni, rsp_valid_i && !rsp_hit_i, rsp_line_accesses_i == '0, "miss with nonzero hit count")

  // No eviction means no evicted block number.
  `ACWB_ASSERT_IMP(a_no_repl_block, clk_i, rst_ni, rsp_valid_i && !rsp_replaced_i, rsp_replaced_block_i == '0, "block number without eviction")

endmodule

bind assoc_cache_fifo_random_wb acwb_checker u_acwb_checker (
  .clk_i                (clk_i),
  .rst_ni               (rst_ni),
  .req_valid_i          (req_i.valid),
  .req_ready_i          (req_i.ready),
  .rsp_valid_i          (rsp_o.valid),
  .rsp_ready_i          (rsp_o.ready),
  .rsp_hit_i            (rsp_o.hit),
  .rsp_read_data_i      (rsp_o.read_data),
  .rsp_replaced_i       (rsp_o.replaced),
  .rsp_replaced_block_i (rsp_o.replaced_block),
  .rsp_line_accesses_i  (rsp_o.line_accesses)
);

/* tb/assoc_cache_fifo_random_wb_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// assoc_cache_fifo_random_wb_test
// Self-checking bench for the associative write-back cache. Request words are
// queued phase by phase, driven with random gaps but in one steady phase, and
// each accepted one is run through a behavioral copy of cache and backing memory.
// Every response word is compared field by field, in order, with that prediction.
// ----------------------------------------------------------------------------
module assoc_cache_fifo_random_wb_test;
  import acwb_pkg::*;

  localparam logic        MODE_LFSR    = 1'b0;
  localparam logic        MODE_FIFO    = 1'b1;
  localparam int unsigned LINES        = DEF_NUM_LINES;
  localparam int unsigned WORDS        = DEF_BLOCK_WORDS;
  localparam int unsigned BLOCKS       = DEF_MEM_WORDS / DEF_BLOCK_WORDS;
  localparam int unsigned IDLE_PCT     = 16;
  localparam int unsigned HOLD_AT_WORD = 120;
  localparam int unsigned HOLD_CYCLES  = 150;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned MAX_REPORTS  = 50;

  typedef struct packed {
    op_e               operation;
    logic [ADDR_W-1:0] address;
    logic [DATA_W-1:0] write_data;
  } cache_req_t;

  typedef struct packed {
    logic                  hit;
    logic [LINE_OUT_W-1:0] line_index;
    logic [OFF_OUT_W-1:0]  word_offset;
    logic [DATA_W-1:0]     read_data;
    logic                  replaced;
    logic [BLK_OUT_W-1:0]  replaced_block;
    logic [CNT_W-1:0]      line_accesses;
  } cache_rsp_t;

  logic clk_i;
  logic rst_ni;

  acwb_req_if req_if ();
  acwb_rsp_if rsp_if ();
  acwb_cfg_if cfg_if ();

  assoc_cache_fifo_random_wb u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if),
    .cfg_i  (cfg_if)
  );

  // Behavioral copy of the cache state.
  logic [DATA_W-1:0]    mem_model   [DEF_MEM_WORDS];
  logic [DATA_W-1:0]    line_words  [LINES*WORDS];
  logic [BLK_OUT_W-1:0] line_tag    [LINES];
  logic                 line_valid  [LINES];
  logic [CNT_W-1:0]     line_hits   [LINES];
  logic [CNT_W-1:0]     line_writes [LINES];
  int unsigned          fill_order  [$];
  logic [LFSR_W-1:0]    victim_lfsr;
  logic                 victim_mode;

  // Request generation bookkeeping.
  cache_req_t  pending_reqs  [$];
  cache_rsp_t  expected_rsp  [$];
  bit          word_defined  [DEF_MEM_WORDS];
  bit          block_listed  [BLOCKS];
  int unsigned usable_blocks [$];
  int unsigned recent_blocks [$];
  int unsigned queued_total = 0;
  int unsigned req_count    = 0;
  int unsigned rsp_count    = 0;
  int unsigned error_count  = 0;
  int unsigned hold_left    = 0;
  logic        hold_done    = 1'b0;
  logic        req_fire     = 1'b0;
  logic        steady_run   = 1'b0;

  function automatic cache_rsp_t cache_lookup(input cache_req_t r);
    cache_rsp_t           res;
    logic [BLK_OUT_W-1:0] blk;
    logic [BLK_OUT_W-1:0] old_blk;
    int unsigned          off;
    int unsigned          line;
    int unsigned          filled;
    logic                 found;
    res = '0;
    if (r.operation == OP_PRELOAD) begin
      mem_model[r.address] = r.write_data;
      res.read_data = r.write_data;
      return res;
    end
    if (r.operation == OP_NONE) begin
      return res;
    end
    blk    = r.address / WORDS;
    off    = r.address % WORDS;
    found  = 1'b0;
    line   = 0;
    filled = 0;
    for (int i = 0; i < LINES; i++) begin
      if (line_valid[i]) begin
        filled++;
        if (!found && line_tag[i] == blk) begin
          found = 1'b1;
          line  = i;
        end
      end
    end
    if (found) begin
      if (line_hits[line] != '1) line_hits[line]++;
      if (r.operation == OP_WRITE) begin
        line_words[line*WORDS+off] = r.write_data;
        if (line_writes[line] != '1) line_writes[line]++;
      end
    end else begin
      if (filled < LINES) begin
        for (int i = LINES - 1; i >= 0; i--) begin
          if (!line_valid[i]) line = i;
        end
        line_valid[line] = 1'b1;
        fill_order.push_back(line);
      end else begin
        if (victim_mode == MODE_FIFO) begin
          line = fill_order[0];
        end else begin
          victim_lfsr = victim_lfsr[0] ? ((victim_lfsr >> 1) ^ LFSR_TAPS) : (victim_lfsr >> 1);
          line = victim_lfsr % LINES;
        end
        old_blk = line_tag[line];
        for (int w = 0; w < WORDS; w++) begin
          mem_model[old_blk*WORDS+w] = line_words[line*WORDS+w];
        end
        // The victim goes to the back of the fill order in either mode.
        for (int i = 0; i < fill_order.size(); i++) begin
          if (fill_order[i] == line) begin
            fill_order.delete(i);
            break;
          end
        end
        fill_order.push_back(line);
        res.replaced       = 1'b1;
        res.replaced_block = old_blk;
      end
      for (int w = 0; w < WORDS; w++) begin
        line_words[line*WORDS+w] = mem_model[blk*WORDS+w];
      end
      line_tag[line]    = blk;
      line_hits[line]   = '0;
      line_writes[line] = '0;
    end
    res.hit           = found;
    res.line_index    = line;
    res.word_offset   = off;
    res.read_data     = line_words[line*WORDS+off];
    res.line_accesses = line_hits[line];
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    error_count++;
    if (error_count <= MAX_REPORTS) $display("MISMATCH at %0t: %s", $time, msg);
  endtask

  task automatic push_req(input op_e op, input int unsigned addr, input int unsigned data);
    int unsigned blk;
    bit          complete;
    pending_reqs.push_back(cache_req_t'{op, addr[ADDR_W-1:0], data[DATA_W-1:0]});
    queued_total++;
    blk = addr / WORDS;
    if (op == OP_PRELOAD) begin
      word_defined[addr] = 1'b1;
      complete = 1'b1;
      for (int w = 0; w < WORDS; w++) complete &= word_defined[blk*WORDS+w];
      // Only blocks whose words are all in memory may ever be loaded.
      if (complete && !block_listed[blk]) begin
        block_listed[blk] = 1'b1;
        usable_blocks.push_back(blk);
      end
    end else if (op != OP_NONE) begin
      recent_blocks.push_back(blk);
      if (recent_blocks.size() > 6) void'(recent_blocks.pop_front());
    end
  endtask

  task automatic preload_block(input int unsigned blk);
    for (int w = 0; w < WORDS; w++) push_req(OP_PRELOAD, blk*WORDS + w, $urandom_range(0, 65535));
  endtask

  // Mostly accesses to a small working set so that hits, fills and evictions
  // all happen often; preloads and unused operations are mixed in as noise.
  task automatic random_phase(input int unsigned n);
    int unsigned roll;
    int unsigned blk;
    repeat (n) begin
      roll = $urandom_range(0, 99);
      if (usable_blocks.size() < 8 || roll < 4) begin
        preload_block($urandom_range(0, BLOCKS - 1));
      end else if (roll < 12) begin
        push_req(OP_PRELOAD, $urandom_range(0, DEF_MEM_WORDS - 1), $urandom);
      end else if (roll < 15) begin
        push_req(OP_NONE, $urandom_range(0, DEF_MEM_WORDS - 1), $urandom);
      end else begin
        if (recent_blocks.size() != 0 && $urandom_range(0, 99) < 65) begin
          blk = recent_blocks[$urandom_range(0, recent_blocks.size() - 1)];
        end else begin
          blk = usable_blocks[$urandom_range(0, usable_blocks.size() - 1)];
        end
        push_req($urandom_range(0, 1) ? OP_WRITE : OP_READ,
                 blk*WORDS + $urandom_range(0, WORDS - 1), $urandom);
      end
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk_i); while (req_count != queued_total || rsp_count != req_count);
  endtask

  task automatic write_mode(input logic mode);
    @(negedge clk_i);
    cfg_if.replacement_mode <= mode;
    cfg_if.valid            <= 1'b1;
    do @(posedge clk_i); while (!cfg_if.ready);
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Request driver: a word is held until taken, then replaced or dropped.
  always @(negedge clk_i) begin
    cache_req_t next_req;
    if (rst_ni && (!req_if.valid || req_fire)) begin
      if (pending_reqs.size() != 0 && (steady_run || $urandom_range(0, 99) >= IDLE_PCT)) begin
        next_req = pending_reqs.pop_front();
        req_if.operation  <= next_req.operation;
        req_if.address    <= next_req.address;
        req_if.write_data <= next_req.write_data;
        req_if.valid      <= 1'b1;
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  // Response receiver, with one long hold-off that backs the block up.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      rsp_if.ready <= 1'b0;
    end else if (!hold_done && rsp_count >= HOLD_AT_WORD) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= steady_run || $urandom_range(0, 99) >= IDLE_PCT;
    end
  end

  // Monitor: predicts at request acceptance, checks at response acceptance.
  always @(posedge clk_i) begin
    cache_rsp_t got;
    cache_rsp_t want;
    if (!rst_ni) begin
      req_fire <= 1'b0;
    end else begin
      req_fire <= req_if.valid && req_if.ready;
      if (cfg_if.valid && cfg_if.ready) victim_mode = cfg_if.replacement_mode;
      if (req_if.valid && req_if.ready) begin
        expected_rsp.push_back(cache_lookup(cache_req_t'{op_e'(req_if.operation),
                                                         req_if.address, req_if.write_data}));
        req_count++;
      end
      if (rsp_if.valid && rsp_if.ready) begin
        got = cache_rsp_t'{rsp_if.hit, rsp_if.line_index, rsp_if.word_offset,
                           rsp_if.read_data, rsp_if.replaced, rsp_if.replaced_block,
                           rsp_if.line_accesses};
        rsp_count++;
        if (expected_rsp.size() == 0) begin
          report_mismatch($sformatf("response word %0d with no request outstanding", rsp_count));
        end else begin
          want = expected_rsp.pop_front();
          if (got.hit !== want.hit)
            report_mismatch($sformatf("word %0d hit %0h, expected %0h",
                                      rsp_count, got.hit, want.hit));
          if (got.line_index !== want.line_index)
            report_mismatch($sformatf("word %0d line_index %0h, expected %0h",
                                      rsp_count, got.line_index, want.line_index));
          if (got.word_offset !== want.word_offset)
            report_mismatch($sformatf("word %0d word_offset %0h, expected %0h",
                                      rsp_count, got.word_offset, want.word_offset));
          if (got.read_data !== want.read_data)
            report_mismatch($sformatf("word %0d read_data %0h, expected %0h",
                                      rsp_count, got.read_data, want.read_data));
          if (got.replaced !== want.replaced)
            report_mismatch($sformatf("word %0d replaced %0h, expected %0h",
                                      rsp_count, got.replaced, want.replaced));
          if (got.replaced_block !== want.replaced_block)
            report_mismatch($sformatf("word %0d replaced_block %0h, expected %0h",
                                      rsp_count, got.replaced_block, want.replaced_block));
          if (got.line_accesses !== want.line_accesses)
            report_mismatch($sformatf("word %0d line_accesses %0h, expected %0h",
                                      rsp_count, got.line_accesses, want.line_accesses));
        end
      end
    end
  end

  initial begin
    rst_ni                  = 1'b0;
    req_if.valid            = 1'b0;
    req_if.operation        = OP_READ;
    req_if.address          = '0;
    req_if.write_data       = '0;
    rsp_if.ready            = 1'b0;
    cfg_if.valid            = 1'b0;
    cfg_if.replacement_mode = MODE_LFSR;
    for (int i = 0; i < LINES; i++) begin
      line_valid[i]  = 1'b0;
      line_tag[i]    = '0;
      line_hits[i]   = '0;
      line_writes[i] = '0;
    end
    victim_lfsr = LFSR_SEED;
    victim_mode = MODE_LFSR;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Random victims: field extremes, fills, write on a miss, a first eviction.
    write_mode(MODE_LFSR);
    push_req(OP_NONE, DEF_MEM_WORDS - 1, 16'hFFFF);
    push_req(OP_NONE, 0, 16'h0000);
    preload_block(0);
    preload_block(BLOCKS - 1);
    push_req(OP_PRELOAD, 0, 16'h0000);
    push_req(OP_PRELOAD, DEF_MEM_WORDS - 1, 16'hFFFF);
    preload_block(17);
    preload_block(600);
    preload_block(341);
    push_req(OP_READ, 0, 0);
    push_req(OP_WRITE, DEF_MEM_WORDS - 1, 16'h1234);
    push_req(OP_WRITE, DEF_MEM_WORDS - 2, 16'hFFFF);
    push_req(OP_READ, DEF_MEM_WORDS - 2, 0);
    push_req(OP_READ, 17*WORDS + 1, 0);
    push_req(OP_READ, 600*WORDS + 2, 0);
    push_req(OP_READ, 341*WORDS + 3, 0);
    push_req(OP_READ, 0, 0);
    random_phase(120);
    wait_drained();

    // FIFO victims: a preload to a cached block is lost at its write-back,
    // while a written word survives the round trip through memory.
    write_mode(MODE_FIFO);
    for (int b = 100; b <= 104; b++) preload_block(b);
    for (int b = 100; b <= 103; b++) push_req(OP_READ, b*WORDS, 0);
    push_req(OP_WRITE, 101*WORDS + 2, 16'hBEEF);
    push_req(OP_PRELOAD, 100*WORDS + 1, 16'h0F0F);
    push_req(OP_READ, 104*WORDS, 0);
    push_req(OP_READ, 100*WORDS + 1, 0);
    push_req(OP_READ, 101*WORDS + 2, 0);
    random_phase(120);
    wait_drained();

    write_mode(MODE_LFSR);
    steady_run = 1'b1;
    random_phase(120);
    wait_drained();
    steady_run = 1'b0;

    // Last phase runs with FIFO victims again.
    write_mode(MODE_FIFO);
    random_phase(60);
    wait_drained();

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #40000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
